/* hw/rtl/pcg_pkg.sv */
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared widths, constants, request codes and the XSH-RR output function of
// the PCG32 random generator.
// ----------------------------------------------------------------------------
package pcg_pkg;

   // data widths
   localparam int STATE_W    = 64;
   localparam int WORD_W     = 32;
   localparam int STREAM_W   = 63;
   localparam int REQ_W      = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int ROT_W      = 5;
   localparam int CNT_W      = $clog2(STATE_W);
   localparam int DIV_CNT_W  = $clog2(WORD_W);

   // last bit step of a multiply pass and of a divide pass
   localparam logic [CNT_W-1:0]     DRAW_LAST = CNT_W'(STATE_W - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(WORD_W - 1);

   // generator constants
   localparam logic [STATE_W-1:0] LCG_MULT   = 64'd6364136223846793005;
   localparam logic [STATE_W-1:0] INIT_STATE = 64'h853c49e6748fea9b;
   localparam logic [STATE_W-1:0] INIT_INC   = 64'hda3e39cb94b95bdb;
   localparam int XSH_SHIFT = 18;
   localparam int XSH_LOW   = 27;

   // request codes
   localparam logic [REQ_W-1:0] REQ_RAW     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_BOUNDED = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RESEED  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM = 1'b1;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DRAW = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // what the current multiply pass belongs to
   typedef enum logic [1:0] {
      OP_RAW         = 2'd0,
      OP_BOUNDED     = 2'd1,
      OP_SEED_FIRST  = 2'd2,
      OP_SEED_SECOND = 2'd3
   } op_type;

   // xorshift high bits, then rotate right by the top five state bits
   function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
      logic [STATE_W-1:0]  mixed;
      logic [WORD_W-1:0]   x;
      logic [ROT_W-1:0]    r;
      logic [2*WORD_W-1:0] twice;
      mixed = s ^ (s >> XSH_SHIFT);
      x     = mixed[XSH_LOW +: WORD_W];
      r     = s[STATE_W-1 -: ROT_W];
      twice = {x, x} >> r;
      return twice[WORD_W-1:0];
   endfunction

endpackage

/* hw/rtl/pcg_req_if.sv */
// ----------------------------------------------------------------------------
// pcg_req_if
// Request channel: request kind and bound, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcg_req_if import pcg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [WORD_W-1:0] bound;

   modport source (output valid, req_type, bound, input ready);
   modport sink   (input valid, req_type, bound, output ready);
endinterface

/* hw/rtl/pcg_rsp_if.sv */
// ----------------------------------------------------------------------------
// pcg_rsp_if
// Response channel: one word per request (zero for a reseed), valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcg_rsp_if import pcg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_value;

   modport source (output valid, random_value, input ready);
   modport sink   (input valid, random_value, output ready);
endinterface

/* hw/rtl/pcg32_random_generator.sv */
// ----------------------------------------------------------------------------
// pcg32_random_generator
// PCG32 (XSH-RR, 64-bit LCG) generator with raw draws, bounded draws by
// rejection and reseeding from two configuration registers.
//
//   channel  direction  payload                     handshake
//   req_if   in         req_type[1:0], bound[31:0]  valid / ready
//   rsp_if   out        random_value[31:0]          valid / ready
//   csr_*    in         csr_index[0], csr_wdata     csr_we, no wait
//
// A raw draw runs one multiply pass: the LCG step is a bit-serial carry-save
// multiplier that consumes one state bit per cycle. A bounded draw adds a
// divide pass for the threshold, a multiply pass per rejected draw and a
// divide pass for the final modulo (restoring divider, one quotient bit per
// cycle). A reseed takes two multiply passes. Reset loads the initial state
// at once, with no clearing pass. A stalled result waits in the output
// register while the next request is accepted and worked on.
// ----------------------------------------------------------------------------
module pcg32_random_generator import pcg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pcg_req_if.sink              req_if,
   pcg_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STATE_W-1:0]   csr_wdata
);

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic                 div_mod_ff, div_mod_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [STATE_W-1:0]   lcg_state_ff, lcg_state_in;
   logic [STATE_W-1:0]   lcg_inc_ff, lcg_inc_in;
   logic [STATE_W-1:0]   seed_ff, seed_in;
   logic [STREAM_W-1:0]  stream_ff, stream_in;
   logic [STATE_W-1:0]   sum_ff, sum_in;
   logic [STATE_W-1:0]   car_ff, car_in;
   logic [1:0]           cy_ff, cy_in;
   logic [WORD_W-1:0]    draw_ff, draw_in;
   logic [WORD_W-1:0]    thresh_ff, thresh_in;
   logic [WORD_W-1:0]    bound_ff, bound_in;
   logic [WORD_W-1:0]    result_ff, result_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    num_ff, num_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                 req_fire;
   logic [STATE_W-1:0]   part_prod;
   logic [STATE_W-1:0]   fa_sum;
   logic [STATE_W-1:0]   fa_car;
   logic                 seed_bit;
   logic [2:0]           add_bits;
   logic [WORD_W:0]      div_trial;
   logic                 div_ge;
   logic [WORD_W-1:0]    div_diff;
   logic [WORD_W-1:0]    div_rem;

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign req_fire            = req_if.valid & req_if.ready;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.random_value = rsp_data_ff;

   // carry-save row: add the multiplier bit times the constant into the row
   assign part_prod = lcg_state_ff[0] ? LCG_MULT : '0;
   assign fa_sum    = sum_ff ^ car_ff ^ part_prod;
   assign fa_car    = (sum_ff & car_ff) | (sum_ff & part_prod) | (car_ff & part_prod);

   // serial adder: product bit plus increment bit plus seed bit on the first reseed pass
   assign seed_bit = (op_ff == OP_SEED_FIRST) & seed_ff[0];
   assign add_bits = {2'b00, fa_sum[0]} + {2'b00, lcg_inc_ff[0]} + {2'b00, seed_bit}
                   + {1'b0, cy_ff};

   // restoring divider step; the difference fits the word whenever it is taken
   assign div_trial = {rem_ff, num_ff[WORD_W-1]};
   assign div_ge    = (div_trial >= {1'b0, bound_ff});
   assign div_diff  = div_trial[WORD_W-1:0] - bound_ff;
   assign div_rem   = div_ge ? div_diff : div_trial[WORD_W-1:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      div_mod_in   = div_mod_ff;
      cnt_in       = cnt_ff;
      lcg_state_in = lcg_state_ff;
      lcg_inc_in   = lcg_inc_ff;
      seed_in      = seed_ff;
      stream_in    = stream_ff;
      sum_in       = sum_ff;
      car_in       = car_ff;
      cy_in        = cy_ff;
      draw_in      = draw_ff;
      thresh_in    = thresh_ff;
      bound_in     = bound_ff;
      result_in    = result_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // write configuration registers
      if (csr_we) begin
         case (csr_index)
            CSR_SEED:   seed_in   = csr_wdata;
            CSR_STREAM: stream_in = csr_wdata[STREAM_W-1:0];
            default:    ;
         endcase
      end

      // drop the result once the transaction completes
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               bound_in = req_if.bound;
               case (req_if.req_type)
                  REQ_RAW: begin
                     op_in    = OP_RAW;
                     sum_in   = '0;
                     car_in   = '0;
                     cy_in    = '0;
                     cnt_in   = '0;
                     state_in = ST_DRAW;
                  end
                  REQ_BOUNDED: begin
                     if (req_if.bound == '0) begin
                        op_in    = OP_RAW;
                        sum_in   = '0;
                        car_in   = '0;
                        cy_in    = '0;
                        cnt_in   = '0;
                        state_in = ST_DRAW;
                     end else begin
                        // threshold = (2^32 - bound) mod bound
                        op_in      = OP_BOUNDED;
                        num_in     = '0 - req_if.bound;
                        rem_in     = '0;
                        div_mod_in = 1'b0;
                        cnt_in     = '0;
                        state_in   = ST_DIV;
                     end
                  end
                  REQ_RESEED: begin
                     lcg_state_in = '0;
                     lcg_inc_in   = {stream_ff, 1'b1};
                     op_in        = OP_SEED_FIRST;
                     sum_in       = '0;
                     car_in       = '0;
                     cy_in        = '0;
                     cnt_in       = '0;
                     state_in     = ST_DRAW;
                  end
                  default: begin
                     result_in = '0;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end

         ST_DRAW: begin
            // take the output word from the old state before it shifts
            if (cnt_ff == '0) begin
               draw_in = xsh_rr(lcg_state_ff);
            end
            // advance one bit: new state bits enter at the top
            lcg_state_in = {add_bits[0], lcg_state_ff[STATE_W-1:1]};
            cy_in        = add_bits[2:1];
            sum_in       = {1'b0, fa_sum[STATE_W-1:1]};
            car_in       = fa_car;
            lcg_inc_in   = {lcg_inc_ff[0], lcg_inc_ff[STATE_W-1:1]};
            seed_in      = {seed_ff[0], seed_ff[STATE_W-1:1]};
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DRAW_LAST) begin
               case (op_ff)
                  OP_RAW: begin
                     result_in = draw_ff;
                     state_in  = ST_DONE;
                  end
                  OP_SEED_FIRST: begin
                     op_in  = OP_SEED_SECOND;
                     sum_in = '0;
                     car_in = '0;
                     cy_in  = '0;
                  end
                  OP_SEED_SECOND: begin
                     result_in = '0;
                     state_in  = ST_DONE;
                  end
                  OP_BOUNDED: begin
                     if (draw_ff >= thresh_ff) begin
                        num_in     = draw_ff;
                        rem_in     = '0;
                        div_mod_in = 1'b1;
                        cnt_in     = '0;
                        state_in   = ST_DIV;
                     end else begin
                        // reject and draw again
                        sum_in = '0;
                        car_in = '0;
                        cy_in  = '0;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_DIV: begin
            rem_in = div_rem;
            num_in = {num_ff[WORD_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[DIV_CNT_W-1:0] == DIV_LAST) begin
               if (div_mod_ff) begin
                  result_in = div_rem;
                  state_in  = ST_DONE;
               end else begin
                  thresh_in = div_rem;
                  sum_in    = '0;
                  car_in    = '0;
                  cy_in     = '0;
                  cnt_in    = '0;
                  state_in  = ST_DRAW;
               end
            end
         end

         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_RAW;
         div_mod_ff   <= 1'b0;
         cnt_ff       <= '0;
         lcg_state_ff <= INIT_STATE;
         lcg_inc_ff   <= INIT_INC;
         seed_ff      <= '0;
         stream_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         div_mod_ff   <= div_mod_in;
         cnt_ff       <= cnt_in;
         lcg_state_ff <= lcg_state_in;
         lcg_inc_ff   <= lcg_inc_in;
         seed_ff      <= seed_in;
         stream_ff    <= stream_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      car_ff      <= car_in;
      cy_ff       <= cy_in;
      draw_ff     <= draw_in;
      thresh_ff   <= thresh_in;
      bound_ff    <= bound_in;
      result_ff   <= result_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // an accepted request always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start work");

   // a multiply pass runs its full length
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAW) && (cnt_ff != DRAW_LAST)) |=> (state_ff == ST_DRAW))
      else $error("multiply pass ended early");

   // the divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < bound_ff))
      else $error("divider remainder out of range");

   // the first reseed pass starts from a zero state
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAW) && (op_ff == OP_SEED_FIRST) && (cnt_ff == '0))
         |-> (lcg_state_ff == '0))
      else $error("reseed pass did not start from zero");
`endif

endmodule
